FILE: design/dmx_rdm_frame_receiver_unit_macros.svh
// ------------------------------------------------------------------------------------------
// DMX/RDM receiver assertion macros
// Shared concurrent assertion forms for the receiver RTL.
// ------------------------------------------------------------------------------------------
`ifndef DMX_RDM_FRAME_RECEIVER_UNIT_MACROS_SVH
`define DMX_RDM_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define DMXRDM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmxrdm: same-cycle check failed");

// next-cycle implication
`define DMXRDM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmxrdm: next-cycle check failed");

`endif

FILE: design/dmxrdm_pkg.sv
// ------------------------------------------------------------------------------------------
// DMX/RDM receiver package
// Sizes, protocol codes and the structs passed between the receiver modules.
// ------------------------------------------------------------------------------------------
package dmxrdm_pkg;

   localparam int SLOT_WINDOW    = 4;   // 1..16
   localparam int PARAM_CAPACITY = 32;  // 1..231
   localparam int HDR_DEPTH      = 24;

   localparam int SLOT_AW  = (SLOT_WINDOW > 1) ? $clog2(SLOT_WINDOW) : 1;
   localparam int PARAM_AW = (PARAM_CAPACITY > 1) ? $clog2(PARAM_CAPACITY) : 1;
   localparam int HDR_AW   = 5;

   // start codes
   localparam logic [7:0] SC_DMX = 8'h00;
   localparam logic [7:0] SC_RDM = 8'hCC;
   localparam logic [7:0] SC_SUB = 8'h01;

   localparam logic [HDR_AW-1:0] HDR_TOP     = HDR_AW'(HDR_DEPTH - 1);
   localparam logic [HDR_AW-1:0] HDR_PDL_POS = HDR_AW'(2);

   // register map (word index)
   localparam logic REG_START_ADDRESS = 1'b0;
   localparam logic REG_TIMEOUT_LIMIT = 1'b1;

   localparam logic [9:0]  START_ADDRESS_RST = 10'd1;
   localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1200;

   typedef struct packed {
      logic [9:0]  start_address;
      logic [15:0] timeout_limit_ms;
   } csr_type;

   typedef struct packed {
      logic                slot_we;
      logic [SLOT_AW-1:0]  slot_addr;
      logic                hdr_we;
      logic [HDR_AW-1:0]   hdr_addr;
      logic                param_we;
      logic [PARAM_AW-1:0] param_addr;
      logic [7:0]          data;
   } store_wr_type;

   typedef struct packed {
      logic        slot_store_valid;
      logic [3:0]  slot_position;
      logic        rdm_store_valid;
      logic        rdm_in_param_area;
      logic [7:0]  rdm_position;
      logic [7:0]  stored_byte;
      logic        dmx_frame_done;
      logic        rdm_message_done;
      logic        break_seen;
      logic        timeout_flag;
      logic [15:0] frame_period_ms;
      logic [2:0]  receiver_phase;
   } result_type;

endpackage

FILE: design/dmx_rdm_frame_receiver_unit.sv
// ------------------------------------------------------------------------------------------
// DMX512 / RDM frame receiver
// Decodes UART receive beats and millisecond ticks into slot/RDM store events.
// ------------------------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_type, req_rx_byte, req_framing_error
//  rsp_      out        rsp_valid / rsp_stall  one result beat per request beat
//  csr (APB) in         psel/penable/pwrite    start_address @0x0, timeout_limit_ms @0x4
//
//  One request beat per cycle while req_stall is low; the result is registered, or parked in the skid entry.
//  Throughput is set by the phase/counter loop in the core: one beat a cycle unless stalled.
//  The PDL byte comes from a registered header memory read, forwarded when just written.
//  Result path: output register plus one skid entry; req_stall rises only when both hold
//  beats. Synchronous active-high reset clears control state; stores need no clearing.
//
module dmx_rdm_frame_receiver_unit
   import dmxrdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_framing_error,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_slot_store_valid,
   output logic [3:0]  rsp_slot_position,
   output logic        rsp_rdm_store_valid,
   output logic        rsp_rdm_in_param_area,
   output logic [7:0]  rsp_rdm_position,
   output logic [7:0]  rsp_stored_byte,
   output logic        rsp_dmx_frame_done,
   output logic        rsp_rdm_message_done,
   output logic        rsp_break_seen,
   output logic        rsp_timeout_flag,
   output logic [15:0] rsp_frame_period_ms,
   output logic [2:0]  rsp_receiver_phase,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "dmx_rdm_frame_receiver_unit_macros.svh"

   csr_type      csr_ff;
   logic         csr_wr;
   logic         req_acc;
   logic         rsp_take;
   logic [7:0]   pdl;
   store_wr_type store_wr;
   result_type   core_res;

   result_type   out_ff;
   logic         out_valid_ff;
   result_type   skid_ff;
   logic         skid_valid_ff;

   // ---- configuration port ----
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_address    <= START_ADDRESS_RST;
         csr_ff.timeout_limit_ms <= TIMEOUT_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_START_ADDRESS: csr_ff.start_address    <= pwdata[9:0];
            REG_TIMEOUT_LIMIT: csr_ff.timeout_limit_ms <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_START_ADDRESS: prdata = {22'd0, csr_ff.start_address};
         REG_TIMEOUT_LIMIT: prdata = {16'd0, csr_ff.timeout_limit_ms};
      endcase
   end

   // ---- request side: stall only once the skid entry is taken ----
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   dmxrdm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .acc           (req_acc),
      .req_type      (req_type),
      .rx_byte       (req_rx_byte),
      .framing_error (req_framing_error),
      .csr           (csr_ff),
      .pdl           (pdl),
      .wr            (store_wr),
      .res           (core_res)
   );

   dmxrdm_store u_store (
      .clock (clock),
      .reset (reset),
      .wr    (store_wr),
      .pdl   (pdl)
   );

   // ---- result buffering: output register and skid entry ----
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= core_res;
            out_valid_ff <= req_acc;
         end
      end else if (req_acc) begin
         // output held by stall: park the new beat
         skid_ff       <= core_res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_slot_store_valid  = out_ff.slot_store_valid;
   assign rsp_slot_position     = out_ff.slot_position;
   assign rsp_rdm_store_valid   = out_ff.rdm_store_valid;
   assign rsp_rdm_in_param_area = out_ff.rdm_in_param_area;
   assign rsp_rdm_position      = out_ff.rdm_position;
   assign rsp_stored_byte       = out_ff.stored_byte;
   assign rsp_dmx_frame_done    = out_ff.dmx_frame_done;
   assign rsp_rdm_message_done  = out_ff.rdm_message_done;
   assign rsp_break_seen        = out_ff.break_seen;
   assign rsp_timeout_flag      = out_ff.timeout_flag;
   assign rsp_frame_period_ms   = out_ff.frame_period_ms;
   assign rsp_receiver_phase    = out_ff.receiver_phase;

   // ---- checks ----
   `DMXRDM_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `DMXRDM_ASSERT_NXT(a_skid_fills, clock, reset, out_valid_ff && rsp_stall && req_acc, skid_valid_ff)
   `DMXRDM_ASSERT_NXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, out_valid_ff && !skid_valid_ff)
   `DMXRDM_ASSERT_IMP(a_one_store, clock, reset, out_valid_ff, !(out_ff.slot_store_valid && out_ff.rdm_store_valid))

endmodule

FILE: design/dmxrdm_store.sv
// ------------------------------------------------------------------------------------------
// DMX/RDM receiver byte stores
// Slot, RDM header and parameter memories; registered PDL read with write forwarding.
// ------------------------------------------------------------------------------------------
module dmxrdm_store
   import dmxrdm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  store_wr_type wr,
   output logic [7:0]   pdl
);

   logic [7:0] slot_mem  [SLOT_WINDOW];
   logic [7:0] hdr_mem   [HDR_DEPTH];
   logic [7:0] param_mem [PARAM_CAPACITY];

   logic [7:0] pdl_rd_ff;
   logic       fwd_valid_ff;
   logic       fwd_valid_in;
   logic [7:0] fwd_data_ff;

   assign fwd_valid_in = wr.hdr_we && (wr.hdr_addr == HDR_PDL_POS);

   always_ff @(posedge clock) begin
      if (wr.slot_we) begin
         slot_mem[wr.slot_addr] <= wr.data;
      end
      if (wr.hdr_we) begin
         hdr_mem[wr.hdr_addr] <= wr.data;
      end
      if (wr.param_we) begin
         param_mem[wr.param_addr] <= wr.data;
      end
      pdl_rd_ff   <= hdr_mem[HDR_PDL_POS];
      fwd_data_ff <= wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // the registered array read still holds the old byte after a write: take the written byte directly then
   assign pdl = fwd_valid_ff ? fwd_data_ff : pdl_rd_ff;

endmodule

FILE: design/dmxrdm_core.sv
// ------------------------------------------------------------------------------------------
// DMX/RDM receiver core
// Receive phase machine, slot/header/parameter counters, timeout and period counters.
// ------------------------------------------------------------------------------------------
module dmxrdm_core
   import dmxrdm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         acc,
   input  logic         req_type,
   input  logic [7:0]   rx_byte,
   input  logic         framing_error,
   input  csr_type      csr,
   input  logic [7:0]   pdl,
   output store_wr_type wr,
   output result_type   res
);

   typedef enum logic [2:0] {
      PH_WAIT_BREAK = 3'd0,
      PH_WAIT_START = 3'd1,
      PH_DMX_DATA   = 3'd2,
      PH_RDM_SUB    = 3'd3,
      PH_RDM_HDR    = 3'd4,
      PH_RDM_PARAM  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [9:0]  slot_ff, slot_in;
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  par_cnt_ff, par_cnt_in;
   logic        par_taken_ff, par_taken_in;
   logic [15:0] idle_ff, idle_in;
   logic        tmo_ff, tmo_in;
   logic [15:0] run_ff, run_in;
   logic [15:0] last_ff, last_in;

   logic [9:0]  slot_diff;
   logic [10:0] win_end;
   logic [4:0]  hdr_pos;
   logic [7:0]  par_pos;
   logic [7:0]  pdl_clamp;
   logic [7:0]  par_floor;

   assign slot_diff = slot_ff - csr.start_address;
   assign win_end   = {1'b0, csr.start_address} + 11'(SLOT_WINDOW);
   assign hdr_pos   = (hdr_cnt_ff > HDR_TOP) ? HDR_TOP : hdr_cnt_ff;
   assign par_pos   = (par_cnt_ff >= 8'(PARAM_CAPACITY)) ? 8'(PARAM_CAPACITY - 1) : par_cnt_ff;
   assign pdl_clamp = (pdl > 8'(PARAM_CAPACITY)) ? 8'(PARAM_CAPACITY) : pdl;
   assign par_floor = 8'(PARAM_CAPACITY) - pdl_clamp;

   always_comb begin
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      par_cnt_in   = par_cnt_ff;
      par_taken_in = par_taken_ff;
      idle_in      = idle_ff;
      tmo_in       = tmo_ff;
      run_in       = run_ff;
      last_in      = last_ff;
      wr           = '0;
      wr.data      = rx_byte;
      res          = '0;

      if (acc) begin
         if (req_type) begin
            idle_in = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
            run_in  = (run_ff == 16'hFFFF) ? run_ff : run_ff + 16'd1;
         end else if (framing_error) begin
            res.break_seen = 1'b1;
            phase_in       = PH_WAIT_START;
            idle_in        = '0;
         end else begin
            unique case (phase_ff)
               PH_WAIT_START: begin
                  if (rx_byte == SC_DMX) begin
                     phase_in = PH_DMX_DATA;
                     slot_in  = 10'd1;
                     last_in  = run_ff;
                     run_in   = '0;
                  end else if (rx_byte == SC_RDM) begin
                     phase_in = PH_RDM_SUB;
                  end else begin
                     phase_in = PH_WAIT_BREAK;
                  end
               end
               PH_DMX_DATA: begin
                  if (csr.start_address != '0 && slot_ff >= csr.start_address &&
                      slot_diff < 10'(SLOT_WINDOW)) begin
                     wr.slot_we           = 1'b1;
                     wr.slot_addr         = slot_diff[SLOT_AW-1:0];
                     res.slot_store_valid = 1'b1;
                     res.slot_position    = slot_diff[3:0];
                     res.stored_byte      = rx_byte;
                  end
                  slot_in = (slot_ff == 10'd1023) ? slot_ff : slot_ff + 10'd1;
                  if (csr.start_address != '0 && {1'b0, slot_in} >= win_end) begin
                     res.dmx_frame_done = 1'b1;
                     phase_in           = PH_WAIT_BREAK;
                     idle_in            = '0;
                     tmo_in             = 1'b0;
                  end
               end
               PH_RDM_SUB: begin
                  if (rx_byte == SC_SUB) begin
                     phase_in     = PH_RDM_HDR;
                     hdr_cnt_in   = HDR_TOP;
                     par_taken_in = 1'b0;
                  end else begin
                     phase_in = PH_WAIT_BREAK;
                  end
               end
               PH_RDM_HDR: begin
                  wr.hdr_we           = 1'b1;
                  wr.hdr_addr         = hdr_pos;
                  res.rdm_store_valid = 1'b1;
                  res.rdm_position    = 8'(hdr_pos);
                  res.stored_byte     = rx_byte;
                  priority if (hdr_pos == HDR_PDL_POS && rx_byte != '0 && !par_taken_ff) begin
                     phase_in   = PH_RDM_PARAM;
                     par_cnt_in = 8'(PARAM_CAPACITY - 1);
                     hdr_cnt_in = 5'd1;
                  end else if (hdr_pos == '0) begin
                     res.rdm_message_done = 1'b1;
                     hdr_cnt_in           = hdr_pos;
                     phase_in             = PH_WAIT_BREAK;
                     idle_in              = '0;
                     tmo_in               = 1'b0;
                  end else begin
                     hdr_cnt_in = hdr_pos - 5'd1;
                  end
               end
               PH_RDM_PARAM: begin
                  wr.param_we           = 1'b1;
                  wr.param_addr         = par_pos[PARAM_AW-1:0];
                  res.rdm_store_valid   = 1'b1;
                  res.rdm_in_param_area = 1'b1;
                  res.rdm_position      = par_pos;
                  res.stored_byte       = rx_byte;
                  if (par_pos <= par_floor) begin
                     phase_in     = PH_RDM_HDR;
                     par_taken_in = 1'b1;
                     par_cnt_in   = par_pos;
                  end else begin
                     par_cnt_in = par_pos - 8'd1;
                  end
               end
               PH_WAIT_BREAK: begin
                  phase_in = PH_WAIT_BREAK;
               end
            endcase
         end

         if (idle_in > csr.timeout_limit_ms) begin
            tmo_in  = 1'b1;
            idle_in = '0;
         end
      end

      res.timeout_flag    = tmo_in;
      res.frame_period_ms = last_in;
      res.receiver_phase  = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT_BREAK;
         slot_ff      <= '0;
         hdr_cnt_ff   <= '0;
         par_cnt_ff   <= '0;
         par_taken_ff <= 1'b0;
         idle_ff      <= '0;
         tmo_ff       <= 1'b0;
         run_ff       <= '0;
         last_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         par_cnt_ff   <= par_cnt_in;
         par_taken_ff <= par_taken_in;
         idle_ff      <= idle_in;
         tmo_ff       <= tmo_in;
         run_ff       <= run_in;
         last_ff      <= last_in;
      end
   end

endmodule

FILE: dv/dmx_rdm_frame_receiver_unit_tb.sv
// ------------------------------------------------------------------------------------------
// DMX512 / RDM frame receiver testbench
// Feeds UART byte, break and tick beats through bursty valid/stall traffic.
// Each beat is decoded by a local receiver model, and the result beats are checked field
// by field in order. The two registers are reprogrammed between traffic phases.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmx_rdm_frame_receiver_unit_tb;
   import dmxrdm_pkg::*;

   // beat kinds on req_type
   localparam logic EV_BYTE = 1'b0;
   localparam logic EV_TICK = 1'b1;

   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
   localparam int DRAIN_CYCLES   = 6;     // result register plus skid, with margin

   typedef enum logic [2:0] {
      PH_WAIT_BREAK = 3'd0,
      PH_WAIT_START = 3'd1,
      PH_DMX_DATA   = 3'd2,
      PH_RDM_SUB    = 3'd3,
      PH_RDM_HDR    = 3'd4,
      PH_RDM_PARAM  = 3'd5
   } rx_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       ferr;
   } uart_event_type;

   // ---------------------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ---------------------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = EV_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_framing_error = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_slot_store_valid;
   logic [3:0]  rsp_slot_position;
   logic        rsp_rdm_store_valid;
   logic        rsp_rdm_in_param_area;
   logic [7:0]  rsp_rdm_position;
   logic [7:0]  rsp_stored_byte;
   logic        rsp_dmx_frame_done;
   logic        rsp_rdm_message_done;
   logic        rsp_break_seen;
   logic        rsp_timeout_flag;
   logic [15:0] rsp_frame_period_ms;
   logic [2:0]  rsp_receiver_phase;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   dmx_rdm_frame_receiver_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_rx_byte           (req_rx_byte),
      .req_framing_error     (req_framing_error),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot_store_valid  (rsp_slot_store_valid),
      .rsp_slot_position     (rsp_slot_position),
      .rsp_rdm_store_valid   (rsp_rdm_store_valid),
      .rsp_rdm_in_param_area (rsp_rdm_in_param_area),
      .rsp_rdm_position      (rsp_rdm_position),
      .rsp_stored_byte       (rsp_stored_byte),
      .rsp_dmx_frame_done    (rsp_dmx_frame_done),
      .rsp_rdm_message_done  (rsp_rdm_message_done),
      .rsp_break_seen        (rsp_break_seen),
      .rsp_timeout_flag      (rsp_timeout_flag),
      .rsp_frame_period_ms   (rsp_frame_period_ms),
      .rsp_receiver_phase    (rsp_receiver_phase),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Receiver model: register copies and decode state
   // ---------------------------------------------------------------------------------------
   logic [9:0]  cfg_start   = START_ADDRESS_RST;
   logic [15:0] cfg_timeout = TIMEOUT_LIMIT_RST;

   rx_phase_type rx_phase    = PH_WAIT_BREAK;
   logic [9:0]  slot_cnt     = '0;
   logic [4:0]  hdr_cnt      = '0;
   logic [7:0]  par_cnt      = '0;
   logic        par_done     = 1'b0;
   logic [15:0] idle_ms      = '0;
   logic        timed_out    = 1'b0;
   logic [15:0] period_run   = '0;
   logic [15:0] period_last  = '0;
   logic [7:0]  pdl_byte     = '0;   // header position 2, the only store entry read back

   uart_event_type uart_events[$];   // beats waiting for the driver
   result_type  reports_due[$];      // decoded results not yet seen on rsp_

   int events_pushed   = 0;
   int events_accepted = 0;
   int results_checked = 0;
   int errors          = 0;
   int frames_done     = 0;
   int messages_done   = 0;
   int breaks_seen     = 0;
   int timeouts_seen   = 0;
   int slots_stored    = 0;
   int params_stored   = 0;

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // completed frame or message: back to idle, timeout cleared
   function automatic void close_packet();
      rx_phase  = PH_WAIT_BREAK;
      idle_ms   = '0;
      timed_out = 1'b0;
   endfunction

   function automatic result_type decode_event(logic kind, logic [7:0] b, logic ferr);
      result_type r;
      int         pos;
      int         pdl;
      r = '0;
      if (kind == EV_TICK) begin
         // a tick never touches the receive phase
         idle_ms    = sat_inc(idle_ms);
         period_run = sat_inc(period_run);
      end else if (ferr) begin
         r.break_seen = 1'b1;
         rx_phase     = PH_WAIT_START;
         idle_ms      = '0;
      end else begin
         case (rx_phase)
            PH_WAIT_START: begin
               if (b == SC_DMX) begin
                  rx_phase    = PH_DMX_DATA;
                  slot_cnt    = 10'd1;
                  period_last = period_run;
                  period_run  = '0;
               end else if (b == SC_RDM) begin
                  rx_phase = PH_RDM_SUB;
               end else begin
                  rx_phase = PH_WAIT_BREAK;
               end
            end
            PH_DMX_DATA: begin
               if (cfg_start != 0 && slot_cnt >= cfg_start) begin
                  pos = int'(slot_cnt) - int'(cfg_start);
                  if (pos < SLOT_WINDOW) begin
                     r.slot_store_valid = 1'b1;
                     r.slot_position    = 4'(pos);
                     r.stored_byte      = b;
                  end
               end
               if (slot_cnt < 10'd1023)
                  slot_cnt = slot_cnt + 10'd1;
               // capture off, or a window that reaches slot 1023, never completes
               if (cfg_start != 0 && int'(slot_cnt) >= int'(cfg_start) + SLOT_WINDOW) begin
                  r.dmx_frame_done = 1'b1;
                  close_packet();
               end
            end
            PH_RDM_SUB: begin
               if (b == SC_SUB) begin
                  rx_phase = PH_RDM_HDR;
                  hdr_cnt  = HDR_TOP;
                  par_done = 1'b0;
               end else begin
                  rx_phase = PH_WAIT_BREAK;
               end
            end
            PH_RDM_HDR: begin
               if (hdr_cnt > HDR_TOP)
                  hdr_cnt = HDR_TOP;
               if (hdr_cnt == HDR_PDL_POS)
                  pdl_byte = b;
               r.rdm_store_valid = 1'b1;
               r.rdm_position    = 8'(hdr_cnt);
               r.stored_byte     = b;
               if (hdr_cnt == HDR_PDL_POS && b != 8'd0 && !par_done) begin
                  rx_phase = PH_RDM_PARAM;
                  par_cnt  = 8'(PARAM_CAPACITY - 1);
                  hdr_cnt  = 5'd1;
               end else if (hdr_cnt == 5'd0) begin
                  r.rdm_message_done = 1'b1;
                  close_packet();
               end else begin
                  hdr_cnt = hdr_cnt - 5'd1;
               end
            end
            PH_RDM_PARAM: begin
               // oversized PDL is clamped to the parameter store size
               pdl = (int'(pdl_byte) > PARAM_CAPACITY) ? PARAM_CAPACITY : int'(pdl_byte);
               if (int'(par_cnt) >= PARAM_CAPACITY)
                  par_cnt = 8'(PARAM_CAPACITY - 1);
               r.rdm_store_valid   = 1'b1;
               r.rdm_in_param_area = 1'b1;
               r.rdm_position      = par_cnt;
               r.stored_byte       = b;
               if (int'(par_cnt) <= PARAM_CAPACITY - pdl) begin
                  rx_phase = PH_RDM_HDR;
                  par_done = 1'b1;
               end else begin
                  par_cnt = par_cnt - 8'd1;
               end
            end
            default: rx_phase = PH_WAIT_BREAK;
         endcase
      end
      if (idle_ms > cfg_timeout) begin
         timed_out = 1'b1;
         idle_ms   = '0;
      end
      r.timeout_flag    = timed_out;
      r.frame_period_ms = period_last;
      r.receiver_phase  = rx_phase;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: bursts of beats with random gaps; a stalled beat is held unchanged
   // ---------------------------------------------------------------------------------------
   logic           req_fire_q = 1'b0;   // beat on req_ taken at the last rising edge
   int             burst_left = 0;
   int             gap_left   = 0;
   logic           next_valid;
   uart_event_type next_ev;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire_q)) begin
         if (gap_left > 0) begin
            gap_left--;
            next_valid = 1'b0;
         end else if (uart_events.size() != 0) begin
            next_ev = uart_events.pop_front();
            next_valid = 1'b1;
            req_type          <= next_ev.kind;
            req_rx_byte       <= next_ev.data;
            req_framing_error <= next_ev.ferr;
            burst_left--;
            if (burst_left <= 0) begin
               case ($urandom_range(0, 5))
                  0: begin   // long stretch with no gaps
                     burst_left = $urandom_range(100, 300);
                     gap_left   = 0;
                  end
                  1, 2: begin
                     burst_left = $urandom_range(1, 4);
                     gap_left   = $urandom_range(1, 6);
                  end
                  default: begin
                     burst_left = $urandom_range(5, 40);
                     gap_left   = $urandom_range(0, 12);
                  end
               endcase
            end
         end else begin
            next_valid = 1'b0;
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side back-pressure: a stall pattern independent of the sender
   // ---------------------------------------------------------------------------------------
   int   stall_left = 0;
   logic stall_next = 1'b0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         case ($urandom_range(0, 7))
            0: begin   // free-running stretch
               stall_next = 1'b0;
               stall_left = $urandom_range(40, 120);
            end
            1, 2: begin
               stall_next = 1'b1;
               stall_left = $urandom_range(1, 20);
            end
            3, 4, 5: begin
               stall_next = 1'b1;
               stall_left = $urandom_range(0, 2);
            end
            default: begin
               stall_next = 1'b0;
               stall_left = $urandom_range(0, 6);
            end
         endcase
      end
      rsp_stall <= reset ? 1'b0 : stall_next;
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: decode each accepted req_ beat, check each accepted rsp_ beat in order
   // ---------------------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   result_type due;

   always @(posedge clock) begin
      if (reset) begin
         req_fire_q <= 1'b0;
      end else begin
         req_fire_q <= req_valid && !req_stall;
         // decode first so a result can never overtake its own beat
         if (req_valid && !req_stall) begin
            reports_due.push_back(decode_event(req_type, req_rx_byte, req_framing_error));
            events_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $error("result beat with no result outstanding");
               errors++;
            end else begin
               due = reports_due.pop_front();
               check_field("slot_store_valid", 16'(due.slot_store_valid),
                           16'(rsp_slot_store_valid));
               check_field("slot_position", 16'(due.slot_position), 16'(rsp_slot_position));
               check_field("rdm_store_valid", 16'(due.rdm_store_valid),
                           16'(rsp_rdm_store_valid));
               check_field("rdm_in_param_area", 16'(due.rdm_in_param_area),
                           16'(rsp_rdm_in_param_area));
               check_field("rdm_position", 16'(due.rdm_position), 16'(rsp_rdm_position));
               check_field("stored_byte", 16'(due.stored_byte), 16'(rsp_stored_byte));
               check_field("dmx_frame_done", 16'(due.dmx_frame_done),
                           16'(rsp_dmx_frame_done));
               check_field("rdm_message_done", 16'(due.rdm_message_done),
                           16'(rsp_rdm_message_done));
               check_field("break_seen", 16'(due.break_seen), 16'(rsp_break_seen));
               check_field("timeout_flag", 16'(due.timeout_flag), 16'(rsp_timeout_flag));
               check_field("frame_period_ms", due.frame_period_ms, rsp_frame_period_ms);
               check_field("receiver_phase", 16'(due.receiver_phase),
                           16'(rsp_receiver_phase));
               results_checked++;
               frames_done   += due.dmx_frame_done;
               messages_done += due.rdm_message_done;
               breaks_seen   += due.break_seen;
               timeouts_seen += due.timeout_flag;
               slots_stored  += due.slot_store_valid;
               params_stored += due.rdm_in_param_area;
            end
         end
      end
   end

   // watchdog: too long without a beat on either channel
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, reports_due.size());
         $display("FAIL dmx_rdm_frame_receiver_unit");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic push_event(logic kind, logic [7:0] b, logic ferr);
      uart_event_type ev;
      ev.kind = kind;
      ev.data = b;
      ev.ferr = ferr;
      uart_events.push_back(ev);
      events_pushed++;
   endtask

   // ticks ignore the byte and error fields, so those are randomised
   task automatic push_tick();
      push_event(EV_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic push_break();
      push_event(EV_BYTE, 8'($urandom), 1'b1);
   endtask

   // a clean byte, now and then preceded by a tick
   task automatic push_data(logic [7:0] b);
      if ($urandom_range(0, 7) == 0)
         push_tick();
      push_event(EV_BYTE, b, 1'b0);
   endtask

   task automatic gen_dmx_frame();
      int len;
      if (cfg_start > 16)
         len = $urandom_range(0, 12);
      else
         len = $urandom_range(0, int'(cfg_start) + SLOT_WINDOW + 2);
      push_break();
      push_data(SC_DMX);
      repeat (len) push_data(8'($urandom));
   endtask

   // one frame of clean slots with no ticks, long enough to reach a high window
   task automatic gen_long_frame(int len);
      push_break();
      push_event(EV_BYTE, SC_DMX, 1'b0);
      repeat (len) push_event(EV_BYTE, 8'($urandom), 1'b0);
   endtask

   task automatic gen_rdm_message();
      logic [7:0] msg[$];
      logic [7:0] pdl;
      int         cut;
      case ($urandom_range(0, 6))
         0: pdl = 8'd0;
         1: pdl = 8'd1;
         2: pdl = 8'(PARAM_CAPACITY);
         3: pdl = 8'($urandom_range(PARAM_CAPACITY + 1, 255));   // clamped
         4: pdl = 8'($urandom);
         default: pdl = 8'($urandom_range(1, PARAM_CAPACITY - 1));
      endcase
      msg.push_back(SC_RDM);
      msg.push_back(SC_SUB);
      for (int pos = HDR_DEPTH - 1; pos >= 0; pos--) begin
         if (pos == int'(HDR_PDL_POS)) begin
            msg.push_back(pdl);
            repeat ((int'(pdl) > PARAM_CAPACITY) ? PARAM_CAPACITY : int'(pdl))
               msg.push_back(8'($urandom));
         end else begin
            msg.push_back(8'($urandom));
         end
      end
      // one message in six is cut short by a break
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, msg.size() - 1) : -1;
      push_break();
      foreach (msg[i]) begin
         if (i == cut) begin
            push_break();
            break;
         end
         push_data(msg[i]);
      end
   endtask

   task automatic gen_malformed();
      logic [7:0] b;
      push_break();
      case ($urandom_range(0, 2))
         0: begin   // unknown start code
            do b = 8'($urandom); while (b == SC_DMX || b == SC_RDM);
            push_data(b);
            push_data(8'($urandom));
         end
         1: begin   // bad sub-start code
            push_data(SC_RDM);
            do b = 8'($urandom); while (b == SC_SUB);
            push_data(b);
         end
         default: begin   // DMX start code and one slot after the break
            push_data(SC_DMX);
            push_data(8'($urandom));
         end
      endcase
   endtask

   task automatic gen_noise();
      if ($urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 60)) push_tick();
      else
         repeat ($urandom_range(1, 6))
            push_event(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (events_accepted != events_pushed || reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write, then read back the same register
   task automatic csr_write(logic reg_idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (reg_idx == REG_START_ADDRESS)
         cfg_start = value[9:0];
      else
         cfg_timeout = value[15:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== value) begin
         $error("prdata: expected %0d, actual %0d", value, prdata);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // one traffic phase: program both registers, optional tick run, then mixed packets
   task automatic run_phase(logic [9:0] start, logic [15:0] limit, int ticks, int budget);
      int first;
      wait_drained();
      csr_write(REG_START_ADDRESS, 32'(start));
      csr_write(REG_TIMEOUT_LIMIT, 32'(limit));
      repeat (ticks) push_tick();
      first = events_pushed;
      while (events_pushed - first < budget) begin
         case ($urandom_range(0, 99)) inside
            [0:39]:  gen_dmx_frame();
            [40:74]: gen_rdm_message();
            [75:87]: gen_malformed();
            default: gen_noise();
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at reset register values
      push_tick();
      push_event(EV_BYTE, 8'h42, 1'b0);   // byte while waiting for a break
      push_event(EV_TICK, 8'hFF, 1'b1);   // tick wins over the error flag
      push_event(EV_BYTE, 8'hA5, 1'b1);   // break
      push_event(EV_BYTE, 8'h55, 1'b0);   // unknown start code
      push_event(EV_BYTE, 8'h00, 1'b1);
      push_event(EV_BYTE, SC_RDM, 1'b0);
      push_event(EV_BYTE, 8'h7E, 1'b0);   // bad sub-start
      push_event(EV_BYTE, 8'hFF, 1'b1);
      push_event(EV_BYTE, SC_DMX, 1'b0);
      push_event(EV_BYTE, 8'h00, 1'b0);   // full window of extreme slot values
      push_event(EV_BYTE, 8'hFF, 1'b0);
      push_event(EV_BYTE, 8'h80, 1'b0);
      push_event(EV_BYTE, 8'h01, 1'b0);   // frame completes here
      push_event(EV_BYTE, 8'h33, 1'b0);
      push_event(EV_BYTE, 8'h00, 1'b1);
      push_event(EV_BYTE, SC_DMX, 1'b0);
      push_event(EV_BYTE, 8'hAA, 1'b0);
      push_event(EV_BYTE, 8'h5A, 1'b1);   // break mid-frame
      push_tick();

      run_phase(10'd4,    16'd3,     0,     160);
      run_phase(10'd0,    16'd0,     0,     90);    // capture off, zero timeout
      run_phase(10'd2,    16'hFFFF,  0,     110);
      run_phase(10'd1,    16'd1200,  0,     90);
      run_phase(10'd512,  16'd25,    0,     50);
      run_phase(10'd1023, 16'd9,     0,     50);
      // slot counter saturates; the last slot is stored again and the frame never ends
      gen_long_frame(1026);
      run_phase(10'($urandom_range(1, 6)), 16'($urandom_range(0, 60)), 0, 110);
      // a tick run ahead of the traffic, no timeout
      run_phase(10'd3,    16'hFFFF,  40,    50);
      wait_drained();

      $display("covered %0d beats, %0d results checked: %0d DMX frames, %0d RDM messages",
               events_accepted, results_checked, frames_done, messages_done);
      $display("%0d slots and %0d parameter bytes stored, %0d breaks, %0d timeout beats",
               slots_stored, params_stored, breaks_seen, timeouts_seen);
      if (errors == 0)
         $display("PASS dmx_rdm_frame_receiver_unit");
      else
         $display("FAIL dmx_rdm_frame_receiver_unit");
      $finish;
   end

endmodule
